### design/ufe_pkg.sv
// Shared types, constants and helpers for the form URL-encoder.
package ufe_pkg;

  // Request opcodes on the input channel.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_SEP   = 2'd2,
    OP_END   = 2'd3
  } opcode_t;

  // Characters that the encoder emits on its own, and the space that it replaces.
  localparam logic [7:0] CHAR_AMP     = 8'h26;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  // Reset value of the buffer length register.
  localparam logic [15:0] BUF_LEN_RESET = 16'd1024;

  // Default depth of the queue between front and back.
  localparam int unsigned UFE_QUEUE_DEPTH = 4;

  // One queued job: either a single output byte or a byte to be escaped.
  typedef struct packed {
    logic       escaped;
    logic [7:0] byte_val;
    logic       term;
    logic       err;
  } ufe_job_t;

endpackage

### design/ufe_in_if.sv
// Input channel: opcode and raw byte with a valid/ready handshake.
interface ufe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

### design/ufe_out_if.sv
// Result channel: one encoded byte and its flags with a valid/ready handshake.
interface ufe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       terminator;
  logic       overflow_error;

  modport source (output valid, output out_byte, output last_of_run,
                  output terminator, output overflow_error, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input terminator, input overflow_error, output ready);
endinterface

### design/ufe_cfg_if.sv
// Configuration channel: write data for the buffer length register.
interface ufe_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] buffer_length;

  modport source (output valid, output buffer_length, input ready);
  modport sink   (input valid, input buffer_length, output ready);
endinterface

### design/url_form_encoder.sv
// Top level of the form URL-encoder: front end, job queue and back end.
//
//   Channel    Direction  Carries
//   in_chan    sink       opcode, data_byte
//   out_chan   source     out_byte, last_of_run, terminator, overflow_error
//   cfg_chan   sink       buffer_length
//
// The front end takes one request per cycle while the queue has room; a request
// that yields output is queued in the same cycle it is accepted.
// The back end sends one byte per cycle while the receiver is ready: the byte itself
// for a single-byte result, a percent sign and two hex digits for an escaped byte.
// Each result is written into the queue and then loaded into the back end's output
// register, from which it is offered on the result channel.
// Reset is synchronous and active low; it clears the count, the error and the
// queue and restores a buffer length of 1024. The two sides stall on their own.
module url_form_encoder #(
  parameter int unsigned QUEUE_DEPTH = ufe_pkg::UFE_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  ufe_in_if.sink    in_chan,
  ufe_out_if.source out_chan,
  ufe_cfg_if.sink   cfg_chan
);
  import ufe_pkg::*;

  logic     q_push, q_full, q_pop, q_not_empty;
  ufe_job_t q_job, q_head;

  ufe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg_chan(cfg_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_job)
  );

  ufe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (q_head),
    .not_empty(q_not_empty)
  );

  ufe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (q_head),
    .not_empty(q_not_empty),
    .pop      (q_pop),
    .out_chan (out_chan)
  );

endmodule

### design/ufe_front.sv
// Front end: accepts requests, classifies bytes, checks room and queues jobs.
module ufe_front (
  input  logic              clk,
  input  logic              rst_n,
  ufe_in_if.sink            in_chan,
  ufe_cfg_if.sink           cfg_chan,
  input  logic              q_full,
  output logic              q_push,
  output ufe_pkg::ufe_job_t q_job
);
  import ufe_pkg::*;

  logic [15:0] buf_len_r;
  logic [15:0] count_r, count_nxt;
  logic        err_r, err_nxt;

  opcode_t     op;
  logic [7:0]  b;
  logic        plain;
  logic        is_space;
  logic        need3;
  logic [17:0] room_sum;
  logic        fits;
  logic        produce;
  logic        accept;

  // Pass-through class: digits, letters and the marks _ - . * =.
  always_comb begin
    plain = ((b >= 8'h30) && (b <= 8'h39)) ||
            ((b >= 8'h61) && (b <= 8'h7A)) ||
            ((b >= 8'h41) && (b <= 8'h5A)) ||
            (b == 8'h5F) || (b == 8'h2D) || (b == 8'h2E) ||
            (b == 8'h2A) || (b == 8'h3D);
  end

  assign op       = opcode_t'(in_chan.opcode);
  assign b        = in_chan.data_byte;
  assign is_space = (b == CHAR_SPACE);
  assign need3    = (op == OP_DATA) && !plain && !is_space;

  // Room check: count plus bytes needed plus terminator must stay below the length.
  assign room_sum = {2'b00, count_r} + (need3 ? 18'd3 : 18'd1) + 18'd1;
  assign fits     = room_sum < {2'b00, buf_len_r};

  assign in_chan.ready  = !q_full;
  assign cfg_chan.ready = 1'b1;
  assign accept         = in_chan.valid && in_chan.ready;

  // Decide what the request produces and how the stream state moves.
  always_comb begin
    count_nxt        = count_r;
    err_nxt          = err_r;
    produce          = 1'b0;
    q_job.escaped    = 1'b0;
    q_job.byte_val   = CHAR_NUL;
    q_job.term       = 1'b0;
    q_job.err        = 1'b0;
    unique case (op)
      OP_START: begin
        count_nxt = '0;
        err_nxt   = 1'b0;
      end
      OP_END: begin
        produce    = 1'b1;
        q_job.term = 1'b1;
        q_job.err  = err_r;
      end
      OP_SEP, OP_DATA: begin
        if (!err_r) begin
          if (!fits) begin
            err_nxt = 1'b1;
          end else begin
            produce   = 1'b1;
            count_nxt = count_r + (need3 ? 16'd3 : 16'd1);
            if (op == OP_SEP) begin
              q_job.byte_val = CHAR_AMP;
            end else if (plain) begin
              q_job.byte_val = b;
            end else if (is_space) begin
              q_job.byte_val = CHAR_PLUS;
            end else begin
              q_job.escaped  = 1'b1;
              q_job.byte_val = b;
            end
          end
        end
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  assign q_push = accept && produce;

  // Stream state and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_len_r <= BUF_LEN_RESET;
      count_r   <= '0;
      err_r     <= 1'b0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        buf_len_r <= cfg_chan.buffer_length;
      end
      if (accept) begin
        count_r <= count_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

### design/ufe_queue.sv
// Small job queue between the front end and the back end.
module ufe_queue #(
  parameter int unsigned DEPTH = ufe_pkg::UFE_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ufe_pkg::ufe_job_t push_job,
  output logic              full,
  input  logic              pop,
  output ufe_pkg::ufe_job_t head_job,
  output logic              not_empty
);
  import ufe_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ufe_job_t      slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head_job  = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### design/ufe_back.sv
// Back end: expands queued jobs into output bytes through an output register.
module ufe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ufe_pkg::ufe_job_t head_job,
  input  logic              not_empty,
  output logic              pop,
  ufe_out_if.source         out_chan
);
  import ufe_pkg::*;

  // Lowercase hex digit for a nibble.
  function automatic logic [7:0] hex_lower(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'h0, nib};
    end else begin
      ch = 8'h57 + {4'h0, nib};
    end
    return ch;
  endfunction

  logic [1:0] phase_r, phase_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       term_r, term_nxt;
  logic       err_r, err_nxt;
  logic       load;

  assign load = !valid_r || out_chan.ready;

  // Pick the next byte of the head job.
  always_comb begin
    phase_nxt = phase_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    term_nxt  = term_r;
    err_nxt   = err_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = not_empty;
      if (not_empty) begin
        term_nxt = head_job.term;
        err_nxt  = head_job.err;
        if (!head_job.escaped) begin
          byte_nxt = head_job.byte_val;
          last_nxt = 1'b1;
          pop      = 1'b1;
        end else begin
          unique case (phase_r)
            2'd0: begin
              byte_nxt  = CHAR_PERCENT;
              last_nxt  = 1'b0;
              phase_nxt = 2'd1;
            end
            2'd1: begin
              byte_nxt  = hex_lower(head_job.byte_val[7:4]);
              last_nxt  = 1'b0;
              phase_nxt = 2'd2;
            end
            default: begin
              byte_nxt  = hex_lower(head_job.byte_val[3:0]);
              last_nxt  = 1'b1;
              phase_nxt = 2'd0;
              pop       = 1'b1;
            end
          endcase
        end
      end
    end
  end

  // Control state resets; the payload register does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    term_r <= term_nxt;
    err_r  <= err_nxt;
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.out_byte       = byte_r;
  assign out_chan.last_of_run    = last_r;
  assign out_chan.terminator     = term_r;
  assign out_chan.overflow_error = err_r;

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the form URL-encoder, with a built-in encoding predictor.
`timescale 1ns / 1ps

module tb;
  import ufe_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned TIMEOUT       = 2000;
  localparam int unsigned PHASE_ITEMS   = 36;
  localparam int unsigned MAX_REPORTS   = 10;

  // One encoded character as it leaves the result channel.
  typedef struct packed {
    logic [7:0] chr;
    logic       is_last;
    logic       is_term;
    logic       ovf;
  } enc_char_t;

  // What a request is expected to produce, either typed in or left to the predictor.
  typedef struct packed {
    logic                  typed;
    logic [1:0]            cnt;
    enc_char_t [2:0]       res;
  } req_note_t;

  // One line of the directed table: a register write or a request.
  typedef struct packed {
    logic        is_cfg;
    logic [15:0] cfg_val;
    opcode_t     op;
    logic [7:0]  data;
    req_note_t   note;
  } vec_row_t;

  logic clk;
  logic rst_n;

  ufe_in_if  in_ch ();
  ufe_out_if out_ch ();
  ufe_cfg_if cfg_ch ();

  url_form_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_chan (cfg_ch)
  );

  // Predictor state, mirroring the encoder's count, sticky error and register.
  logic [15:0] written_cnt = '0;
  logic        overflowed  = 1'b0;
  logic [15:0] buf_len     = BUF_LEN_RESET;

  enc_char_t   exp_q[$];
  req_note_t   note_q[$];
  vec_row_t    dir_tab[$];
  req_note_t   untyped_note = '0;

  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left   = 0;
  logic        gappy        = 1'b0;
  logic        hold_req     = 1'b0;
  logic        hold_taken   = 1'b0;

  // Clock with a 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic is_plain(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
           b == "_" || b == "-" || b == "." || b == "*" || b == "=";
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    return (nib < 4'd10) ? 8'("0") + 8'(nib) : 8'("a") + 8'(nib) - 8'd10;
  endfunction

  // Claim room for n output bytes plus the terminator, or raise the sticky error.
  function automatic logic take_room(int n);
    if (overflowed) return 1'b0;
    if (int'(written_cnt) + n + 1 >= int'(buf_len)) begin
      overflowed = 1'b1;
      return 1'b0;
    end
    written_cnt = written_cnt + 16'(n);
    return 1'b1;
  endfunction

  // Work out the characters one request produces and advance the predictor state.
  function automatic req_note_t encode_request(opcode_t op, logic [7:0] b);
    req_note_t r;
    r = '0;
    case (op)
      OP_START: begin
        written_cnt = '0;
        overflowed  = 1'b0;
      end
      OP_END: begin
        r.cnt    = 2'd1;
        r.res[0] = '{chr: CHAR_NUL, is_last: 1'b1, is_term: 1'b1, ovf: overflowed};
      end
      OP_SEP: begin
        if (take_room(1)) begin
          r.cnt    = 2'd1;
          r.res[0] = '{chr: CHAR_AMP, is_last: 1'b1, is_term: 1'b0, ovf: 1'b0};
        end
      end
      default: begin
        if (is_plain(b) || b == CHAR_SPACE) begin
          if (take_room(1)) begin
            r.cnt    = 2'd1;
            r.res[0] = '{chr: (b == CHAR_SPACE) ? CHAR_PLUS : b, is_last: 1'b1,
                         is_term: 1'b0, ovf: 1'b0};
          end
        end else if (take_room(3)) begin
          r.cnt    = 2'd3;
          r.res[0] = '{chr: CHAR_PERCENT, is_last: 1'b0, is_term: 1'b0, ovf: 1'b0};
          r.res[1] = '{chr: hex_char(b[7:4]), is_last: 1'b0, is_term: 1'b0, ovf: 1'b0};
          r.res[2] = '{chr: hex_char(b[3:0]), is_last: 1'b1, is_term: 1'b0, ovf: 1'b0};
        end
      end
    endcase
    return r;
  endfunction

  // Table builders for the directed part.
  task automatic add_pred(opcode_t op, logic [7:0] b);
    vec_row_t row;
    row      = '0;
    row.op   = op;
    row.data = b;
    dir_tab.push_back(row);
  endtask

  task automatic add_known(opcode_t op, logic [7:0] b, int n, logic [7:0] c0,
                           logic [7:0] c1, logic [7:0] c2, logic err);
    vec_row_t row;
    logic [7:0] chars [3];
    row        = '0;
    row.op     = op;
    row.data   = b;
    row.note.typed = 1'b1;
    row.note.cnt   = 2'(n);
    chars = '{c0, c1, c2};
    for (int i = 0; i < n; i++) begin
      row.note.res[i] = '{chr: chars[i], is_last: (i == n - 1), is_term: (op == OP_END),
                          ovf: err};
    end
    dir_tab.push_back(row);
  endtask

  task automatic add_cfg(logic [15:0] v);
    vec_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    dir_tab.push_back(row);
  endtask

  // Offer one request, with burst gaps when the current phase asks for them.
  task automatic send_req(opcode_t op, logic [7:0] b, req_note_t note);
    @(negedge clk);
    if (gappy) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 10);
      end
      burst_left--;
    end
    note_q.push_back(note);
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering, then wait until every expected character has arrived and the
  // back end has had time to finish any request that produced nothing.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_buf_len(logic [15:0] v);
    @(negedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.buffer_length <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random form character: plain in four of ten picks, a space in one, any byte in the rest.
  function automatic logic [7:0] pick_char();
    logic [7:0] marks [5];
    marks = '{"_", "-", ".", "*", "="};
    case ($urandom_range(0, 9))
      0: return 8'("0") + 8'($urandom_range(0, 9));
      1: return 8'("a") + 8'($urandom_range(0, 25));
      2: return 8'("A") + 8'($urandom_range(0, 25));
      3: return marks[$urandom_range(0, 4)];
      4: return CHAR_SPACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: a stall pattern that is picked anew from four modes, plus one long hold-off.
  initial begin : receiver
    int unsigned cyc;
    int unsigned mode;
    cyc  = 0;
    mode = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      cyc++;
      if (cyc % 40 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (cyc % 3 == 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: track register writes, predict on each accepted request, check results.
  always @(posedge clk) begin : monitor
    req_note_t  note;
    req_note_t  pred;
    enc_char_t  got;
    enc_char_t  want;
    logic       busy;
    if (rst_n) begin
      busy = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        buf_len = cfg_ch.buffer_length;
        busy    = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        busy = 1'b1;
        note = (note_q.size() != 0) ? note_q.pop_front() : untyped_note;
        pred = encode_request(opcode_t'(in_ch.opcode), in_ch.data_byte);
        if (note.typed) pred = note;
        for (int i = 0; i < int'(pred.cnt); i++) exp_q.push_back(pred.res[i]);
      end
      if (out_ch.valid && out_ch.ready) begin
        busy = 1'b1;
        got  = '{chr: out_ch.out_byte, is_last: out_ch.last_of_run,
                 is_term: out_ch.terminator, ovf: out_ch.overflow_error};
        if (exp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: byte=%h last=%b term=%b err=%b",
                     got.chr, got.is_last, got.is_term, got.ovf);
        end else begin
          want = exp_q.pop_front();
          if (got.chr !== want.chr || got.is_last !== want.is_last ||
              got.is_term !== want.is_term || got.ovf !== want.ovf) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $write("mismatch: expected byte=%h last=%b term=%b err=%b,",
                     want.chr, want.is_last, want.is_term, want.ovf);
              $display(" got byte=%h last=%b term=%b err=%b",
                       got.chr, got.is_last, got.is_term, got.ovf);
            end
          end
        end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog: too long without any request or result means the block is stuck.
  initial begin : watchdog
    wait (quiet_cycles >= TIMEOUT);
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus: reset, directed table, then random phases over several buffer lengths.
  initial begin : stimulus
    logic [15:0] phase_len [9];
    int unsigned sent;
    int unsigned fields;
    vec_row_t    row;
    phase_len = '{16'd65535, 16'd40, 16'd1, 16'd0, 16'd7, 16'd300, 16'd2, 16'd1024, 16'd13};

    in_ch.valid          = 1'b0;
    in_ch.opcode         = OP_START;
    in_ch.data_byte      = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.buffer_length = '0;
    rst_n                = 1'b0;

    // End straight after reset, then the escape extremes and the plain-set edges.
    add_known(OP_END,   8'h00, 1, CHAR_NUL, 8'h00, 8'h00, 1'b0);
    add_pred (OP_START, 8'h00);
    add_known(OP_DATA,  8'h00, 3, CHAR_PERCENT, "0", "0", 1'b0);
    add_known(OP_DATA,  8'hFF, 3, CHAR_PERCENT, "f", "f", 1'b0);
    add_known(OP_DATA,  CHAR_SPACE, 1, CHAR_PLUS, 8'h00, 8'h00, 1'b0);
    add_known(OP_SEP,   8'h00, 1, CHAR_AMP, 8'h00, 8'h00, 1'b0);
    add_known(OP_SEP,   8'h5A, 1, CHAR_AMP, 8'h00, 8'h00, 1'b0);
    add_pred (OP_DATA,  "z");
    add_pred (OP_DATA,  "A");
    add_pred (OP_DATA,  ":");
    add_pred (OP_DATA,  ".");
    add_pred (OP_DATA,  "/");
    add_pred (OP_DATA,  8'h80);
    add_known(OP_END,   8'h00, 1, CHAR_NUL, 8'h00, 8'h00, 1'b0);
    // Encoding goes on after an end that no start followed.
    add_pred (OP_DATA,  "0");
    // Buffer length of two: everything overflows until a new start.
    add_cfg  (16'd2);
    add_pred (OP_START, 8'h00);
    add_known(OP_DATA,  "a", 0, 8'h00, 8'h00, 8'h00, 1'b0);
    add_known(OP_SEP,   8'h00, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    add_known(OP_END,   8'h00, 1, CHAR_NUL, 8'h00, 8'h00, 1'b1);
    add_pred (OP_START, 8'h00);
    add_known(OP_END,   8'h00, 1, CHAR_NUL, 8'h00, 8'h00, 1'b0);
    add_cfg  (16'd65535);
    add_pred (OP_START, 8'h00);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.is_cfg) begin
        drain();
        write_buf_len(row.cfg_val);
      end else begin
        send_req(row.op, row.data, row.note);
      end
    end

    // Random phases: mostly well-formed forms, some broken ones and noise.
    foreach (phase_len[p]) begin
      drain();
      write_buf_len(phase_len[p]);
      gappy = ($urandom_range(0, 3) != 0);
      if (p == 0) begin
        gappy    = 1'b0;
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) != 0) begin
          send_req(OP_START, 8'($urandom_range(0, 255)), untyped_note);
          sent++;
          fields = $urandom_range(1, 4);
          for (int f = 0; f < int'(fields); f++) begin
            if (f > 0) begin
              send_req(OP_SEP, 8'($urandom_range(0, 255)), untyped_note);
              sent++;
            end
            repeat ($urandom_range(0, 4)) begin
              send_req(OP_DATA, pick_char(), untyped_note);
              sent++;
            end
          end
          if ($urandom_range(0, 7) != 0) begin
            send_req(OP_END, 8'($urandom_range(0, 255)), untyped_note);
            sent++;
          end
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_req(opcode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     untyped_note);
            sent++;
          end
        end
      end
    end

    drain();
    if (fail_count == 0 && exp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
